/* rtl/bcm_pkg.sv */
package bcm_pkg;

	// configuration port
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MORPH_MODE   = 2'd2;

	// register reset values and dimension floor
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int DIM_MIN      = 3;

	// morphology modes
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd3;

	// item opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam int PIXEL_W = 8;
	localparam logic [PIXEL_W-1:0] SET_VALUE = 8'd255;
	localparam logic [PIXEL_W-1:0] CLR_VALUE = 8'd0;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic               op;
		logic [PIXEL_W-1:0] pixel;
	} bcm_in_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] out_pixel;
		logic               frame_last;
	} bcm_out_t;

	// one frame step as handed from front to back
	// row_upN: row (current row - N) is an interior row
	// col_left/mid/right: column c-1, c, c+1 is an interior column
	typedef struct packed {
		logic src;
		logic emit;
		logic last;
		logic row_cur;
		logic row_up1;
		logic row_up2;
		logic row_up3;
		logic col_left;
		logic col_mid;
		logic col_right;
	} bcm_step_t;

	// per-column history word of the line store
	typedef struct packed {
		logic src_up1;
		logic src_up2;
		logic mid_up2;
		logic mid_up3;
	} bcm_word_t;

endpackage

/* rtl/binary_cross_morphology_top.sv */
// Binary morphology with a 3x3 cross kernel on a raster frame.
// Input channel (item_valid / item_stall / item): one item per frame pixel in
// row-major order, op = pixel or flush. A pixel is set only when it is 255.
// Output channel (res_valid / res_stall / res): pixels of 0 or 255, with
// frame_last on the final pixel of the frame.
// The result for frame pixel k comes with item k + 2*W (W = frame width), so
// 2*W flush items after the frame push out the last two rows; extra flush
// items give nothing, and flush items inside the frame are dropped.
// Throughput: one item per clock while the receiver does not stall. An accepted
// item is written into the front queue; when the back end pops it, the result
// that it releases is registered in the back end's output register. The back
// end reads one column word of the line store and writes one per item, which
// sets the rate.
// Config: cfg_we writes register cfg_index (0 width, 1 height, 2 mode) and
// restarts the frame; write only while the block is idle.
// Reset: width 640, height 480, erode, frame position zero. No clearing pass.
// Receiver stall: the output register holds its item, the four-entry queue
// fills, then item_stall rises.
module binary_cross_morphology_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bcm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  bcm_pkg::bcm_in_t                    item,
	output logic                                res_valid,
	input  logic                                res_stall,
	output bcm_pkg::bcm_out_t                   res
);
	import bcm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH+4);
	localparam int HW = $clog2(MAX_HEIGHT+4);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WX = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
	localparam int HX = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
	localparam int SW = $bits(bcm_step_t);
	localparam int QW = SW + 2*AW;
	localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int H_RESET = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

	logic [CW-1:0]     width_q;
	logic [HW-1:0]     height_q;
	logic [MODE_W-1:0] mode_q;
	logic [WX-1:0]     w_raw;
	logic [HX-1:0]     h_raw;
	logic [CW-1:0]     w_clamp;
	logic [HW-1:0]     h_clamp;
	logic              cfg_hit;
	logic              restart;

	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	bcm_step_t         f_step;
	logic [AW-1:0]     f_col;
	logic [AW-1:0]     f_rd_col;
	logic [QW-1:0]     q_rdata;
	bcm_step_t         b_step;
	logic [AW-1:0]     b_col;
	logic [AW-1:0]     b_rd_col;

	// clamp dimensions into the supported range
	assign w_raw = WX'(cfg_data);
	assign h_raw = HX'(cfg_data);

	always_comb begin
		if (w_raw < WX'(DIM_MIN)) begin
			w_clamp = CW'(DIM_MIN);
		end else if (w_raw > WX'(MAX_WIDTH)) begin
			w_clamp = CW'(MAX_WIDTH);
		end else begin
			w_clamp = CW'(w_raw);
		end
		if (h_raw < HX'(DIM_MIN)) begin
			h_clamp = HW'(DIM_MIN);
		end else if (h_raw > HX'(MAX_HEIGHT)) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = HW'(h_raw);
		end
	end

	// a write to a listed register restarts the frame
	always_comb begin
		case (cfg_index)
			CFG_FRAME_WIDTH:  cfg_hit = 1'b1;
			CFG_FRAME_HEIGHT: cfg_hit = 1'b1;
			CFG_MORPH_MODE:   cfg_hit = 1'b1;
			default:          cfg_hit = 1'b0;
		endcase
	end

	assign restart = cfg_we & cfg_hit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CW'(W_RESET);
			height_q <= HW'(H_RESET);
			mode_q   <= MODE_ERODE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= w_clamp;
				CFG_FRAME_HEIGHT: height_q <= h_clamp;
				CFG_MORPH_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				default:          mode_q   <= mode_q;
			endcase
		end
	end

	// front: accept and classify
	bcm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.frame_width  (width_q),
		.frame_height (height_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_stall   (item_stall),
		.queue_full   (q_full),
		.push         (push),
		.step         (f_step),
		.col          (f_col),
		.rd_col       (f_rd_col)
	);

	// queue between front and back
	bcm_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (restart),
		.push   (push),
		.wdata  ({f_col, f_rd_col, f_step}),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign b_step   = bcm_step_t'(q_rdata[SW-1:0]);
	assign b_rd_col = q_rdata[SW +: AW];
	assign b_col    = q_rdata[SW+AW +: AW];

	// back: line store, two kernel stages, output register
	bcm_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.morph_mode (mode_q),
		.empty      (q_empty),
		.step       (b_step),
		.col        (b_col),
		.rd_col     (b_rd_col),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule

/* rtl/bcm_front.sv */
module bcm_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   restart,
	input  logic [$clog2(MAX_WIDTH+4)-1:0]         frame_width,
	input  logic [$clog2(MAX_HEIGHT+4)-1:0]        frame_height,
	input  logic                                   item_valid,
	input  bcm_pkg::bcm_in_t                       item,
	output logic                                   item_stall,
	input  logic                                   queue_full,
	output logic                                   push,
	output bcm_pkg::bcm_step_t                     step,
	output logic [$clog2(MAX_WIDTH)-1:0]           col,
	output logic [$clog2(MAX_WIDTH)-1:0]           rd_col
);
	import bcm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH+4);
	localparam int HW = $clog2(MAX_HEIGHT+4);
	localparam int AW = $clog2(MAX_WIDTH);

	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic          accept;
	logic          in_frame;
	logic [CW-1:0] col_ahead;
	logic [CW-1:0] col_next;

	// accept while the queue has room
	assign item_stall = queue_full;
	assign accept     = item_valid & ~queue_full;
	assign in_frame   = row_q < frame_height;

	// flush ticks inside the frame are dropped
	assign push = accept & ~(in_frame & (item.op == OP_FLUSH));

	// classify the step for the back end
	always_comb begin
		step.src       = in_frame & (item.pixel == SET_VALUE);
		step.emit      = row_q >= HW'(2);
		step.last      = (row_q == frame_height + HW'(1)) &&
			(col_q == frame_width - CW'(1));
		step.row_cur   = (row_q >= HW'(1)) && (row_q + HW'(2) <= frame_height);
		step.row_up1   = (row_q >= HW'(2)) && (row_q + HW'(1) <= frame_height);
		step.row_up2   = (row_q >= HW'(3)) && (row_q <= frame_height);
		step.row_up3   = (row_q >= HW'(4)) && (row_q <= frame_height + HW'(1));
		step.col_left  = col_q >= CW'(2);
		step.col_mid   = (col_q >= CW'(1)) && (col_q + CW'(2) <= frame_width);
		step.col_right = col_q + CW'(3) <= frame_width;
	end

	// column two steps ahead, wrapped into the next row
	always_comb begin
		col_ahead = col_q + CW'(2);
		if (col_ahead >= frame_width) begin
			col_ahead = col_ahead - frame_width;
		end
	end

	assign col_next = col_q + CW'(1);
	assign col      = col_q[AW-1:0];
	assign rd_col   = col_ahead[AW-1:0];

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (step.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_next >= frame_width) begin
				col_q <= '0;
				row_q <= row_q + HW'(1);
			end else begin
				col_q <= col_next;
			end
		end
	end

endmodule

/* rtl/bcm_fifo.sv */
module bcm_fifo #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import bcm_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full  = count_q == (PW+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (clear) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + (PW+1)'(1);
				2'b01: count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/bcm_back.sv */
module bcm_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           restart,
	input  logic [bcm_pkg::MODE_W-1:0]     morph_mode,
	input  logic                           empty,
	input  bcm_pkg::bcm_step_t             step,
	input  logic [$clog2(MAX_WIDTH)-1:0]   col,
	input  logic [$clog2(MAX_WIDTH)-1:0]   rd_col,
	output logic                           pop,
	output logic                           res_valid,
	input  logic                           res_stall,
	output bcm_pkg::bcm_out_t              res
);
	import bcm_pkg::*;

	bcm_word_t col_mem [MAX_WIDTH];
	bcm_word_t hold_q;
	bcm_word_t rd_q;
	bcm_word_t new_word;
	logic      left_src_q;
	logic      left_mid_q;
	logic      res_valid_q;
	bcm_out_t  res_q;

	logic int1;
	logic int2;
	logic erode1;
	logic dilate1;
	logic stage1;
	logic erode2;
	logic dilate2;
	logic res_bit;

	// take a step when the output register is free or draining
	assign pop = ~empty & (~res_valid_q | ~res_stall);

	// first stage at the row above the incoming row
	always_comb begin
		int1    = step.row_up1 & step.col_mid;
		erode1  = int1 & hold_q.src_up2 & hold_q.src_up1 & left_src_q &
			rd_q.src_up1 & step.src;
		dilate1 = (int1 & hold_q.src_up1) |
			(step.row_up2 & step.col_mid & hold_q.src_up2) |
			(step.row_cur & step.col_mid & step.src) |
			(step.row_up1 & step.col_left & left_src_q) |
			(step.row_up1 & step.col_right & rd_q.src_up1);
		stage1  = ((morph_mode == MODE_ERODE) || (morph_mode == MODE_OPEN)) ?
			erode1 : dilate1;
	end

	// second stage two rows above the incoming row
	always_comb begin
		int2    = step.row_up2 & step.col_mid;
		erode2  = int2 & hold_q.mid_up3 & hold_q.mid_up2 & left_mid_q &
			rd_q.mid_up2 & stage1;
		dilate2 = (int2 & hold_q.mid_up2) |
			(step.row_up3 & step.col_mid & hold_q.mid_up3) |
			(step.row_up1 & step.col_mid & stage1) |
			(step.row_up2 & step.col_left & left_mid_q) |
			(step.row_up2 & step.col_right & rd_q.mid_up2);
		case (morph_mode)
			MODE_ERODE:  res_bit = hold_q.mid_up2;
			MODE_DILATE: res_bit = hold_q.mid_up2;
			MODE_OPEN:   res_bit = dilate2;
			MODE_CLOSE:  res_bit = erode2;
			default:     res_bit = hold_q.mid_up2;
		endcase
	end

	// column history shifted down by one row
	always_comb begin
		new_word.src_up1 = step.src;
		new_word.src_up2 = hold_q.src_up1;
		new_word.mid_up2 = stage1;
		new_word.mid_up3 = hold_q.mid_up2;
	end

	// line store and column window
	always_ff @(posedge clk) begin
		if (pop) begin
			col_mem[col] <= new_word;
			rd_q         <= col_mem[rd_col];
			hold_q       <= rd_q;
			left_src_q   <= hold_q.src_up1;
			left_mid_q   <= hold_q.mid_up2;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.out_pixel  <= res_bit ? SET_VALUE : CLR_VALUE;
			res_q.frame_last <= step.last;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (restart) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= step.emit;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
